>>> sv/fct_pkg.sv
// package: opcodes, verdict codes and widths for the frustum cull test
`timescale 1ns / 1ps
package fct_pkg;
	localparam int NumPlanesDef = 6;
	localparam int FracBitsDef = 16;
	localparam int CoordW = 32;
	localparam int ProdW = 64;
	localparam int SumW = 68;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SPHERE = 2'd1,
		OP_BOX = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		V_OUTSIDE = 2'd0,
		V_PARTIAL = 2'd1,
		V_INSIDE = 2'd2
	} verdict_t;
endpackage

>>> sv/frustum_cull_test.sv
`timescale 1ns / 1ps
// Frustum cull test: holds NUM_PLANES planes (x, y, z, d in signed Q16.16) loaded by load
// transfers and tests spheres or axis-aligned boxes against all of them in parallel lanes.
// A four-stage pipeline (corner select, 32x32 products, lane sums, verdict reduce)
// accepts one transfer per cycle while the output is not stalled and gives one verdict
// transfer per test from the verdict stage; loads give no result. A load takes effect for
// every test accepted after it. Stalls at the output hold the whole pipeline. Planes reset to zero.
module frustum_cull_test #(
	parameter int NUM_PLANES = fct_pkg::NumPlanesDef,
	parameter int FRAC_BITS = fct_pkg::FracBitsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[1:0], plane_index[4:2], first_x..first_w, second_x..second_z [228:5], zero fill
	input  logic [231:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// verdict[1:0], zero fill
	output logic [7:0]   m_tdata
);
	localparam int CW = fct_pkg::CoordW;
	localparam int PW = fct_pkg::ProdW;
	localparam int SW = fct_pkg::SumW;

	logic [1:0] op_in;
	logic [2:0] idx_in;
	logic signed [CW-1:0] ax, ay, az, aw, bx, by, bz;
	assign op_in = s_tdata[1:0];
	assign idx_in = s_tdata[4:2];
	assign ax = s_tdata[36:5];
	assign ay = s_tdata[68:37];
	assign az = s_tdata[100:69];
	assign aw = s_tdata[132:101];
	assign bx = s_tdata[164:133];
	assign by = s_tdata[196:165];
	assign bz = s_tdata[228:197];

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic box_s1, box_s2, box_s3;
	assign adv = !v_s4 || m_tready;
	assign s_tready = adv;

	// plane store
	logic signed [CW-1:0] pn_q [NUM_PLANES][4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++)
				for (int k = 0; k < 4; k++) pn_q[p][k] <= '0;
		end else if (s_tvalid && adv && op_in == fct_pkg::OP_LOAD &&
				{29'd0, idx_in} < NUM_PLANES) begin
			pn_q[idx_in[$clog2(NUM_PLANES > 1 ? NUM_PLANES : 2)-1:0]][0] <= ax;
			pn_q[idx_in[$clog2(NUM_PLANES > 1 ? NUM_PLANES : 2)-1:0]][1] <= ay;
			pn_q[idx_in[$clog2(NUM_PLANES > 1 ? NUM_PLANES : 2)-1:0]][2] <= az;
			pn_q[idx_in[$clog2(NUM_PLANES > 1 ? NUM_PLANES : 2)-1:0]][3] <= aw;
		end
	end

	// stage 1: corner select per lane, plane snapshot, bias
	logic signed [CW-1:0] n_s1 [NUM_PLANES][3];
	logic signed [CW-1:0] pf_s1 [NUM_PLANES][3];
	logic signed [CW-1:0] pb_s1 [NUM_PLANES][3];
	logic signed [CW:0] bias_s1 [NUM_PLANES];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			box_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid && (op_in == fct_pkg::OP_SPHERE || op_in == fct_pkg::OP_BOX);
			box_s1 <= op_in == fct_pkg::OP_BOX;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				n_s1[p][0] <= pn_q[p][0];
				n_s1[p][1] <= pn_q[p][1];
				n_s1[p][2] <= pn_q[p][2];
				if (op_in == fct_pkg::OP_BOX) begin
					pf_s1[p][0] <= pn_q[p][0][CW-1] ? ax : bx;
					pf_s1[p][1] <= pn_q[p][1][CW-1] ? ay : by;
					pf_s1[p][2] <= pn_q[p][2][CW-1] ? az : bz;
					pb_s1[p][0] <= pn_q[p][0][CW-1] ? bx : ax;
					pb_s1[p][1] <= pn_q[p][1][CW-1] ? by : ay;
					pb_s1[p][2] <= pn_q[p][2][CW-1] ? bz : az;
					bias_s1[p] <= {pn_q[p][3][CW-1], pn_q[p][3]};
				end else begin
					pf_s1[p][0] <= ax;
					pf_s1[p][1] <= ay;
					pf_s1[p][2] <= az;
					pb_s1[p][0] <= ax;
					pb_s1[p][1] <= ay;
					pb_s1[p][2] <= az;
					bias_s1[p] <= {pn_q[p][3][CW-1], pn_q[p][3]} + {aw[CW-1], aw};
				end
			end
		end
	end

	// stage 2: products
	logic signed [PW-1:0] mf_s2 [NUM_PLANES][3];
	logic signed [PW-1:0] mb_s2 [NUM_PLANES][3];
	logic signed [CW:0] bias_s2 [NUM_PLANES];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			box_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			box_s2 <= box_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int k = 0; k < 3; k++) begin
					mf_s2[p][k] <= n_s1[p][k] * pf_s1[p][k];
					mb_s2[p][k] <= n_s1[p][k] * pb_s1[p][k];
				end
				bias_s2[p] <= bias_s1[p];
			end
		end
	end

	// stage 3: exact sums, sign only
	logic signed [SW-1:0] bsh [NUM_PLANES];
	logic signed [SW-1:0] sf [NUM_PLANES];
	logic signed [SW-1:0] sb [NUM_PLANES];
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			bsh[p] = SW'(bias_s2[p]) <<< FRAC_BITS;
			sf[p] = SW'(mf_s2[p][0]) + SW'(mf_s2[p][1]) + SW'(mf_s2[p][2]) + bsh[p];
			sb[p] = SW'(mb_s2[p][0]) + SW'(mb_s2[p][1]) + SW'(mb_s2[p][2]) + bsh[p];
		end
	end
	logic [NUM_PLANES-1:0] of_s3, ob_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			box_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			box_s3 <= box_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				of_s3[p] <= sf[p][SW-1];
				ob_s3[p] <= sb[p][SW-1];
			end
		end
	end

	// stage 4: verdict
	fct_pkg::verdict_t vd_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (|of_s3) vd_s4 <= fct_pkg::V_OUTSIDE;
			else if (box_s3 && |ob_s3) vd_s4 <= fct_pkg::V_PARTIAL;
			else if (box_s3) vd_s4 <= fct_pkg::V_INSIDE;
			else vd_s4 <= fct_pkg::V_PARTIAL;
		end
	end
	assign m_tvalid = v_s4;
	assign m_tdata = {6'd0, vd_s4};
endmodule
